// File: rtl/uutp_pkg.sv
package uutp_pkg;

  localparam int unsigned TextLen   = 36;
  localparam int unsigned NumFields = 11;
  localparam int unsigned NodeBytes = 6;

  localparam logic [5:0] PosTextLen = 6'd36;
  localparam logic [5:0] PosMax     = 6'd63;
  localparam logic [7:0] DashChar   = 8'h2D;

  // Field codes, in the order the fields appear in the text.
  localparam logic [3:0] FldTimeLow  = 4'd0;
  localparam logic [3:0] FldTimeMid  = 4'd1;
  localparam logic [3:0] FldTimeHi   = 4'd2;
  localparam logic [3:0] FldClockHi  = 4'd3;
  localparam logic [3:0] FldClockLo  = 4'd4;
  localparam logic [3:0] FldNodeFirst = 4'd5;
  localparam logic [3:0] FldNone     = 4'd11;

  typedef struct packed {
    logic [47:0] node_id;
    logic [7:0]  clock_seq_lo;
    logic [7:0]  clock_seq_hi;
    logic [15:0] time_hi_version;
    logic [15:0] uuid_mid;
    logic [31:0] uuid_low;
    logic        format_ok;
  } result_t;

  localparam int unsigned ResultBits = $bits(result_t);
  localparam int unsigned OutBytes   = (ResultBits + 7) / 8;
  localparam int unsigned OutBits    = OutBytes * 8;

  // Which field a character position belongs to; dash slots give FldNone.
  function automatic logic [3:0] slot_field(input logic [5:0] pos);
    logic [3:0] f;
    f = FldNone;
    if (pos < 6'd8) begin
      f = FldTimeLow;
    end else if (pos >= 6'd9 && pos < 6'd13) begin
      f = FldTimeMid;
    end else if (pos >= 6'd14 && pos < 6'd18) begin
      f = FldTimeHi;
    end else if (pos >= 6'd19 && pos < 6'd21) begin
      f = FldClockHi;
    end else if (pos >= 6'd21 && pos < 6'd23) begin
      f = FldClockLo;
    end else if (pos >= 6'd24 && pos < PosTextLen) begin
      f = 4'(FldNodeFirst + 4'((pos - 6'd24) >> 1));
    end
    return f;
  endfunction

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end
    return v;
  endfunction

endpackage

// File: rtl/uutp_in_reg.sv
module uutp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] char_i,
  input  logic       last_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       last_o
);
  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;
endmodule

// File: rtl/uutp_core.sv
module uutp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_i,
  input  logic              last_i,
  output uutp_pkg::result_t result_o
);
  import uutp_pkg::*;

  logic [5:0]           pos_q, pos_d;
  logic                 dashes_q, dashes_d;
  logic [NumFields-1:0] stopped_q, stopped_d;
  logic [31:0]          tlow_q, tlow_d;
  logic [15:0]          tmid_q, tmid_d;
  logic [15:0]          thi_q, thi_d;
  logic [7:0]           chi_q, chi_d;
  logic [7:0]           clo_q, clo_d;
  logic [7:0]           node_q [NodeBytes];
  logic [7:0]           node_d [NodeBytes];

  logic [3:0] fld;
  logic [4:0] hx;
  logic [2:0] node_idx;
  logic       ok;

  assign fld      = slot_field(pos_q);
  assign hx       = hex_value(char_i);
  assign node_idx = 3'(fld - FldNodeFirst);

  always_comb begin
    pos_d     = pos_q;
    dashes_d  = dashes_q;
    stopped_d = stopped_q;
    tlow_d    = tlow_q;
    tmid_d    = tmid_q;
    thi_d     = thi_q;
    chi_d     = chi_q;
    clo_d     = clo_q;
    node_d    = node_q;
    if (pos_q < PosTextLen) begin
      if (fld == FldNone) begin
        if (char_i != DashChar) begin
          dashes_d = 1'b0;
        end
      end else if (!stopped_q[fld]) begin
        if (hx[4]) begin
          stopped_d[fld] = 1'b1;
        end else begin
          case (fld)
            FldTimeLow: tlow_d = {tlow_q[27:0], hx[3:0]};
            FldTimeMid: tmid_d = {tmid_q[11:0], hx[3:0]};
            FldTimeHi:  thi_d  = {thi_q[11:0], hx[3:0]};
            FldClockHi: chi_d  = {chi_q[3:0], hx[3:0]};
            FldClockLo: clo_d  = {clo_q[3:0], hx[3:0]};
            default:    node_d[node_idx] = {node_q[node_idx][3:0], hx[3:0]};
          endcase
        end
      end
    end
    if (pos_q < PosMax) begin
      pos_d = pos_q + 6'd1;
    end
  end

  // The result sees this character's update; it is only used on the last one.
  assign ok = (pos_d == PosTextLen) && dashes_d;

  always_comb begin
    result_o.format_ok       = ok;
    result_o.uuid_low        = ok ? tlow_d : '0;
    result_o.uuid_mid        = ok ? tmid_d : '0;
    result_o.time_hi_version = ok ? thi_d : '0;
    result_o.clock_seq_hi    = ok ? chi_d : '0;
    result_o.clock_seq_lo    = ok ? clo_d : '0;
    result_o.node_id         = ok ? {node_d[0], node_d[1], node_d[2],
                                     node_d[3], node_d[4], node_d[5]} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      dashes_q  <= 1'b1;
      stopped_q <= '0;
      tlow_q    <= '0;
      tmid_q    <= '0;
      thi_q     <= '0;
      chi_q     <= '0;
      clo_q     <= '0;
      for (int i = 0; i < NodeBytes; i++) begin
        node_q[i] <= '0;
      end
    end else if (step_i) begin
      if (last_i) begin
        pos_q     <= '0;
        dashes_q  <= 1'b1;
        stopped_q <= '0;
        tlow_q    <= '0;
        tmid_q    <= '0;
        thi_q     <= '0;
        chi_q     <= '0;
        clo_q     <= '0;
        for (int i = 0; i < NodeBytes; i++) begin
          node_q[i] <= '0;
        end
      end else begin
        pos_q     <= pos_d;
        dashes_q  <= dashes_d;
        stopped_q <= stopped_d;
        tlow_q    <= tlow_d;
        tmid_q    <= tmid_d;
        thi_q     <= thi_d;
        chi_q     <= chi_d;
        clo_q     <= clo_d;
        node_q    <= node_d;
      end
    end
  end
endmodule

// File: rtl/uuid_text_parser.sv
// Channel   Direction  tdata (low bit up)                         tlast
// s_axis    in         char_byte[7:0]                             last_char
// m_axis    out        format_ok, uuid_low, uuid_mid,             -
//                      time_hi_version, clock_seq_hi,
//                      clock_seq_lo, node_id, 7 zero pad bits
//
// One character can be taken per cycle while no last character waits on a stalled
// result. A character is registered when accepted and parsed from that register,
// and a result appears on m_axis in the cycle after its last character is parsed.
// Reset clears the position, the dash check and all field accumulators. A stalled
// result holds only the parse of a last character; other characters keep flowing until the next last one arrives.
module uuid_text_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // char_byte[7:0]
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // format_ok, uuid_low, uuid_mid, time_hi_version, clock_seq_hi,
  // clock_seq_lo, node_id, zero pad
  output logic [uutp_pkg::OutBits-1:0]   m_axis_tdata
);
  import uutp_pkg::*;

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       take;
  logic       out_valid_q, out_valid_d;
  logic [OutBits-1:0] out_data_q;
  result_t    result;

  // A last character may only be parsed when the result register can take it.
  assign take = in_valid && (!in_last || !out_valid_q || m_axis_tready);

  uutp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .char_i    (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .take_i    (take),
    .valid_o   (in_valid),
    .char_o    (in_char),
    .last_o    (in_last)
  );

  uutp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (take),
    .char_i   (in_char),
    .last_i   (in_last),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && in_last) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_last) begin
      out_data_q <= OutBits'(result);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
endmodule

// File: bench/uuid_text_parser_test.sv
`timescale 1ns / 1ps

module uuid_text_parser_test;
  import uutp_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned RandItems    = 340;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned NumDirCases  = 17;

  localparam result_t RejectAll = '0;
  localparam result_t ZeroOk    = {128'd0, 1'b1};
  localparam result_t AllOnes   = '1;

  typedef struct {
    logic [8*TextLen-1:0] text;        // repeated when len runs past the end
    int                   len;
    int                   patch_pos;   // -1 leaves the text as written
    logic [7:0]           patch_byte;
    bit                   known;       // want is typed in, not predicted
    result_t              want;
  } text_case_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // char_byte[7:0]
  logic                 s_axis_tlast;   // last_char
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // format_ok, uuid_low, uuid_mid, time_hi_version, clock_seq_hi, clock_seq_lo,
  // node_id, zero pad
  logic [OutBits-1:0]   m_axis_tdata;

  // Predictor state.
  logic [5:0]  pos_cnt;
  logic        dash_good;
  logic [10:0] stop_mask;
  logic [31:0] acc_tl;
  logic [15:0] acc_tm;
  logic [15:0] acc_th;
  logic [7:0]  acc_ch;
  logic [7:0]  acc_cl;
  logic [47:0] acc_node;

  result_t     uuid_due_q[$];
  text_case_t  dir_cases [NumDirCases];

  bit          sender_calm;
  bit          receiver_calm;
  bit          hold_req;
  int unsigned chars_sent;
  int unsigned strings_sent;
  int unsigned results_seen;
  int unsigned rejects_seen;
  int unsigned input_stalls;
  int unsigned mismatches;
  int unsigned cycle_cnt;

  uuid_text_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit dash_slot(input int p);
    return p == 8 || p == 13 || p == 18 || p == 23;
  endfunction

  function automatic logic [3:0] field_at(input int p);
    if (dash_slot(p)) return FldNone;
    if (p < 8) return FldTimeLow;
    if (p < 13) return FldTimeMid;
    if (p < 18) return FldTimeHi;
    if (p < 21) return FldClockHi;
    if (p < 23) return FldClockLo;
    return FldNodeFirst + 4'((p - 24) / 2);
  endfunction

  // Bit 4 flags a byte that is not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic void clear_parse();
    pos_cnt   = '0;
    dash_good = 1'b1;
    stop_mask = '0;
    acc_tl    = '0;
    acc_tm    = '0;
    acc_th    = '0;
    acc_ch    = '0;
    acc_cl    = '0;
    acc_node  = '0;
  endfunction

  // Advances the parse by one character; returns 1 with the UUID on the last one.
  function automatic bit scan_char(input logic [7:0] c, input logic is_last,
                                   output result_t r);
    logic [3:0] fld;
    logic [4:0] nib;
    logic [7:0] nb;
    int         sh;
    r = '0;
    if (pos_cnt < PosTextLen) begin
      fld = field_at(int'(pos_cnt));
      if (fld == FldNone) begin
        if (c != DashChar) dash_good = 1'b0;
      end else if (!stop_mask[fld]) begin
        nib = hex_nibble(c);
        if (nib[4]) begin
          stop_mask[fld] = 1'b1;
        end else begin
          case (fld)
            FldTimeLow: acc_tl = {acc_tl[27:0], nib[3:0]};
            FldTimeMid: acc_tm = {acc_tm[11:0], nib[3:0]};
            FldTimeHi:  acc_th = {acc_th[11:0], nib[3:0]};
            FldClockHi: acc_ch = {acc_ch[3:0], nib[3:0]};
            FldClockLo: acc_cl = {acc_cl[3:0], nib[3:0]};
            default: begin
              sh = 8 * (NodeBytes - 1 - int'(fld - FldNodeFirst));
              nb = acc_node[sh +: 8];
              acc_node[sh +: 8] = {nb[3:0], nib[3:0]};
            end
          endcase
        end
      end
    end
    if (pos_cnt != PosMax) pos_cnt = pos_cnt + 6'd1;
    if (!is_last) return 1'b0;
    if (pos_cnt == PosTextLen && dash_good) begin
      r.format_ok       = 1'b1;
      r.uuid_low        = acc_tl;
      r.uuid_mid        = acc_tm;
      r.time_hi_version = acc_th;
      r.clock_seq_hi    = acc_ch;
      r.clock_seq_lo    = acc_cl;
      r.node_id         = acc_node;
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(n - 4'd10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    logic [4:0] v;
    c = 8'($urandom_range(0, 255));
    v = hex_nibble(c);
    if (!v[4]) c = c ^ 8'h80;
    return c;
  endfunction

  // Offers one character and holds it until the request is taken.
  task automatic send_char(input logic [7:0] c, input logic is_last, input bit known,
                           input result_t want);
    result_t guess;
    int      gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
    if (scan_char(c, is_last, guess)) begin
      uuid_due_q.push_back(known ? want : guess);
      strings_sent++;
    end
    gap = sender_calm ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (uuid_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at result %0d, %s: expected %h, got %h",
               results_seen, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    result_t    got;
    result_t    want;
    logic [6:0] pad;
    if (rst_ni) begin
      if (s_axis_tvalid && !s_axis_tready) input_stalls++;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[ResultBits-1:0];
        pad = m_axis_tdata[OutBits-1:ResultBits];
        results_seen++;
        if (!got.format_ok) rejects_seen++;
        if (uuid_due_q.size() == 0) begin
          note_mismatch("result with nothing pending", '0, 64'(got.uuid_low));
        end else begin
          want = uuid_due_q.pop_front();
          if (got.format_ok !== want.format_ok)
            note_mismatch("format_ok", 64'(want.format_ok), 64'(got.format_ok));
          if (got.uuid_low !== want.uuid_low)
            note_mismatch("uuid_low", 64'(want.uuid_low), 64'(got.uuid_low));
          if (got.uuid_mid !== want.uuid_mid)
            note_mismatch("uuid_mid", 64'(want.uuid_mid), 64'(got.uuid_mid));
          if (got.time_hi_version !== want.time_hi_version)
            note_mismatch("time_hi_version", 64'(want.time_hi_version),
                          64'(got.time_hi_version));
          if (got.clock_seq_hi !== want.clock_seq_hi)
            note_mismatch("clock_seq_hi", 64'(want.clock_seq_hi), 64'(got.clock_seq_hi));
          if (got.clock_seq_lo !== want.clock_seq_lo)
            note_mismatch("clock_seq_lo", 64'(want.clock_seq_lo), 64'(got.clock_seq_lo));
          if (got.node_id !== want.node_id)
            note_mismatch("node_id", 64'(want.node_id), 64'(got.node_id));
          if (pad !== '0)
            note_mismatch("pad bits", '0, 64'(pad));
        end
      end
    end
  end

  initial begin : drive_ready
    int stall;
    m_axis_tready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        // Long hold-off so that results back up and the input stalls.
        stall    = HoldCycles;
        hold_req = 1'b0;
      end else if (receiver_calm) begin
        stall = 0;
      end else begin
        stall = gap_len();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("uuid_text_parser_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  c;
    logic [7:0]  txt[$];
    int          k;
    int          n;
    int          str_idx;
    int unsigned rand_start;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    clear_parse();

    dir_cases = '{
      '{"00000000-0000-0000-0000-000000000000", 36, -1, 8'h00, 1'b1, ZeroOk},
      '{"ffffffff-ffff-ffff-ffff-ffffffffffff", 36, -1, 8'h00, 1'b1, AllOnes},
      '{"FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF", 36, -1, 8'h00, 1'b1, AllOnes},
      '{"0123abCD-89aB-cDeF-9f8E-a1B2c3D4e5F6", 36, -1, 8'h00, 1'b0, RejectAll},
      '{"12g45678-9aXc-0G12-z4F5-1a2Q3b4c5d6e", 36, -1, 8'h00, 1'b0, RejectAll},
      // Neighbors of the hex ranges stop their fields.
      '{"9/00000A-F:00-a@00-fG00-00g000000000", 36, 24, 8'h60, 1'b0, RejectAll},
      '{"123e4567-e89b-12d3-a456-426614174000", 36, 3, 8'h00, 1'b0, RejectAll},
      '{"123e4567-e89b-12d3-a456-426614174000", 36, 13, 8'h00, 1'b1, RejectAll},
      '{"123e4567-e89b-12d3-a456-426614174000", 36, 8, 8'h5F, 1'b1, RejectAll},
      '{"123e4567-e89b-12d3-a456-426614174000", 36, 20, 8'h80, 1'b0, RejectAll},
      '{"123e4567-e89b-12d3-a456-426614174000", 36, 35, 8'hFF, 1'b0, RejectAll},
      '{"123e4567-e89b-12d3-a456-426614174000", 36, 0, DashChar, 1'b0, RejectAll},
      '{"123e4567-e89b-12d3-a456-426614174000", 35, -1, 8'h00, 1'b1, RejectAll},
      '{"123e4567-e89b-12d3-a456-426614174000", 37, -1, 8'h00, 1'b1, RejectAll},
      '{"123e4567-e89b-12d3-a456-426614174000", 1, -1, 8'h00, 1'b1, RejectAll},
      // Long enough for the position counter to saturate.
      '{"123e4567-e89b-12d3-a456-426614174000", 70, -1, 8'h00, 1'b1, RejectAll},
      '{"FEDCBA98-7654-3210-fedc-ba9876543210", 36, -1, 8'h00, 1'b0, RejectAll}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_cases[r]) begin
      for (int i = 0; i < dir_cases[r].len; i++) begin
        c = dir_cases[r].text[8*(TextLen-1-(i % TextLen)) +: 8];
        if (i == dir_cases[r].patch_pos) c = dir_cases[r].patch_byte;
        send_char(c, i == dir_cases[r].len - 1, dir_cases[r].known, dir_cases[r].want);
      end
    end
    drain_results();

    rand_start = chars_sent;
    str_idx    = 0;
    while (chars_sent - rand_start < RandItems) begin
      if (str_idx == 1) begin
        hold_req    = 1'b1;
        sender_calm = 1'b1;
      end
      if (str_idx == 4) sender_calm = 1'b0;
      if (str_idx == 5) drain_results();
      if (str_idx == 6) begin
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
      end
      if (str_idx == 8) begin
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
      end

      txt.delete();
      for (int i = 0; i < TextLen; i++) txt.push_back(dash_slot(i) ? DashChar : rand_hex_char());
      // Full well-formed strings while the receiver holds off.
      k = (str_idx >= 1 && str_idx < 4) ? 0 : $urandom_range(0, 99);
      if (k >= 90) begin
        txt.delete();
        repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
      end else if (k >= 82) begin
        n = $urandom_range(1, 70);
        while (txt.size() > n) void'(txt.pop_back());
        while (txt.size() < n) txt.push_back(8'($urandom_range(0, 255)));
      end else if (k >= 72) begin
        repeat ($urandom_range(1, 3)) txt[$urandom_range(0, TextLen - 1)] = rand_non_hex();
      end else if (k >= 60) begin
        txt[$urandom_range(0, TextLen - 1)] = 8'($urandom_range(0, 255));
      end

      foreach (txt[j]) send_char(txt[j], j == txt.size() - 1, 1'b0, RejectAll);
      str_idx++;
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (uuid_due_q.size() != 0) begin
      $display("%0d expected results never arrived", uuid_due_q.size());
      mismatches += uuid_due_q.size();
    end

    $display("Fed %0d characters as %0d strings; %0d UUID results checked, %0d rejected.",
             chars_sent, strings_sent, results_seen, rejects_seen);
    $display("Input was held off for %0d cycles while results backed up.", input_stalls);
    if (mismatches == 0) begin
      $display("uuid_text_parser_test: done, clean");
    end else begin
      $display("uuid_text_parser_test: done, errors");
    end
    $finish;
  end

endmodule
